@@ rtl/core/nfcp_pkg.sv @@
// shared constants, types and neighbor tables of the nearest free cell placer
`default_nettype none
package nfcp_pkg;

	// grid size defaults and the width of the size arithmetic
	localparam int MAX_ROWS_DEF = 64;
	localparam int MAX_COLS_DEF = 64;
	localparam int DIM_W        = 9;

	// command codes of an input word
	localparam logic CMD_SET   = 1'b0;
	localparam logic CMD_PLACE = 1'b1;

	// register indexes and reset value of the size registers
	localparam logic REG_GRID_ROWS = 1'b0;
	localparam logic REG_GRID_COLS = 1'b1;
	localparam logic [6:0] GRID_RESET = 7'd64;

	// last neighbor of the eight
	localparam logic [2:0] NB_LAST = 3'd7;

	// row step of neighbor k: e, se, s, sw, w, nw, n, ne
	function automatic logic signed [1:0] nb_drow(input logic [2:0] k);
		logic signed [1:0] d;
		case (k)
			3'd0: d = 2'sd0;
			3'd1: d = 2'sd1;
			3'd2: d = 2'sd1;
			3'd3: d = 2'sd1;
			3'd4: d = 2'sd0;
			default: d = -2'sd1;
		endcase
		return d;
	endfunction

	// column step of neighbor k
	function automatic logic signed [1:0] nb_dcol(input logic [2:0] k);
		logic signed [1:0] d;
		case (k)
			3'd0: d = 2'sd1;
			3'd1: d = 2'sd1;
			3'd2: d = 2'sd0;
			3'd6: d = 2'sd0;
			3'd7: d = 2'sd1;
			default: d = -2'sd1;
		endcase
		return d;
	endfunction

	// commands from the controller to the datapath
	typedef struct packed {
		logic sweep_en;
		logic set_wr;
		logic start;
		logic pop_rd;
		logic occ_rd;
		logic nb_init;
		logic nb_rd;
		logic nb_wr;
		logic nb_next;
		logic upd_free;
		logic upd_mark;
		logic vclr_en;
		logic emit;
	} ctrl_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic sweep_done;
		logic cmd_place;
		logic req_in_grid;
		logic queue_empty;
		logic occ_free;
		logic nb_in_bounds;
		logic nb_last;
		logic vclr_done;
		logic out_free;
	} dp_stat_t;

endpackage
`default_nettype wire

@@ rtl/core/nfcp_in_if.sv @@
// input word channel of the placer
`default_nettype none
interface nfcp_in_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [5:0] req_row;
	logic [5:0] req_col;
	logic       occ_value;

	modport source (output valid, cmd, req_row, req_col, occ_value, input ready);
	modport sink (input valid, cmd, req_row, req_col, occ_value, output ready);
endinterface
`default_nettype wire

@@ rtl/core/nfcp_out_if.sv @@
// result word channel of the placer
`default_nettype none
interface nfcp_out_if;
	logic       valid;
	logic       ready;
	logic       found;
	logic [5:0] out_row;
	logic [5:0] out_col;

	modport source (output valid, found, out_row, out_col, input ready);
	modport sink (input valid, found, out_row, out_col, output ready);
endinterface
`default_nettype wire

@@ rtl/core/nfcp_dp.sv @@
// placer datapath: occupancy, visited and queue memories, counters, result register
`default_nettype none
module nfcp_dp #(
	parameter int MAX_ROWS = nfcp_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = nfcp_pkg::MAX_COLS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire nfcp_pkg::ctrl_cmd_t        cmd,
	output nfcp_pkg::dp_stat_t              stat,
	input  wire logic                       take,
	input  wire logic                       in_cmd,
	input  wire logic [5:0]                 in_row,
	input  wire logic [5:0]                 in_col,
	input  wire logic                       in_occ,
	input  wire logic [nfcp_pkg::DIM_W-1:0] rows_used,
	input  wire logic [nfcp_pkg::DIM_W-1:0] cols_used,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic                            out_found,
	output logic [5:0]                      out_row,
	output logic [5:0]                      out_col
);
	localparam int RW    = $clog2(MAX_ROWS);
	localparam int CW    = $clog2(MAX_COLS);
	localparam int AW    = RW + CW;
	localparam int DEPTH = 1 << AW;
	localparam int DW    = nfcp_pkg::DIM_W;

	// latched input word
	logic          cmd_q;
	logic [5:0]    req_row_q, req_col_q;
	logic          occ_val_q;

	// search state
	logic [AW:0]   head_q, tail_q, vclr_cnt_q;
	logic          vclr_v_s1;
	logic [AW-1:0] idx_q, sweep_q;
	logic [2:0]    k_q;
	logic [RW-1:0] obj_row_q;
	logic [CW-1:0] obj_col_q;
	logic          found_q;

	// memories and their registered read data
	logic          occ_mem [DEPTH];
	logic          vis_mem [DEPTH];
	logic [AW-1:0] q_mem [DEPTH];
	logic          occ_rd_q, vis_rd_q;
	logic [AW-1:0] q_rd_q;

	// request cell
	logic [DW-1:0] req_row9, req_col9;
	logic [AW-1:0] req_idx;
	logic          req_in_grid;
	assign req_row9    = DW'(req_row_q);
	assign req_col9    = DW'(req_col_q);
	assign req_idx     = {req_row9[RW-1:0], req_col9[CW-1:0]};
	assign req_in_grid = (req_row9 < rows_used) && (req_col9 < cols_used);

	// neighbor k of the expanded cell
	logic signed [DW:0] nb_r, nb_c;
	logic               nb_in;
	logic [AW-1:0]      nb_idx;
	always_comb begin
		nb_r   = $signed((DW+1)'(idx_q[AW-1:CW])) + (DW+1)'(nfcp_pkg::nb_drow(k_q));
		nb_c   = $signed((DW+1)'(idx_q[CW-1:0])) + (DW+1)'(nfcp_pkg::nb_dcol(k_q));
		nb_in  = (nb_r >= 0) && (nb_c >= 0) &&
			(nb_r < $signed({1'b0, rows_used})) && (nb_c < $signed({1'b0, cols_used}));
		nb_idx = {nb_r[RW-1:0], nb_c[CW-1:0]};
	end

	// object cell and its low six bits for the result
	logic [AW-1:0] obj_idx;
	logic [DW-1:0] obj_row9, obj_col9;
	assign obj_idx  = {obj_row_q, obj_col_q};
	assign obj_row9 = DW'(obj_row_q);
	assign obj_col9 = DW'(obj_col_q);

	// occupancy write select
	logic          occ_we, occ_wd;
	logic [AW-1:0] occ_wa;
	always_comb begin
		occ_we = 1'b0;
		occ_wd = 1'b0;
		occ_wa = sweep_q;
		if (cmd.sweep_en) begin
			occ_we = 1'b1;
		end else if (cmd.set_wr) begin
			occ_we = req_in_grid;
			occ_wa = req_idx;
			occ_wd = occ_val_q;
		end else if (cmd.upd_free) begin
			occ_we = 1'b1;
			occ_wa = obj_idx;
		end else if (cmd.upd_mark) begin
			occ_we = 1'b1;
			occ_wa = idx_q;
			occ_wd = 1'b1;
		end
	end

	// visited write select
	logic          vis_we, vis_wd;
	logic [AW-1:0] vis_wa;
	always_comb begin
		vis_we = 1'b0;
		vis_wd = 1'b0;
		vis_wa = sweep_q;
		if (cmd.sweep_en) begin
			vis_we = 1'b1;
		end else if (cmd.start) begin
			vis_we = req_in_grid;
			vis_wa = req_idx;
			vis_wd = 1'b1;
		end else if (cmd.nb_wr) begin
			vis_we = !vis_rd_q;
			vis_wa = nb_idx;
			vis_wd = 1'b1;
		end else if (cmd.vclr_en) begin
			vis_we = vclr_v_s1;
			vis_wa = q_rd_q;
		end
	end

	// queue ports
	logic          q_we, q_re;
	logic [AW-1:0] q_wa, q_wd, q_ra;
	logic          vclr_more;
	assign vclr_more = vclr_cnt_q != tail_q;
	always_comb begin
		q_we = cmd.start || (cmd.nb_wr && !vis_rd_q);
		q_wa = cmd.start ? '0 : tail_q[AW-1:0];
		q_wd = cmd.start ? req_idx : nb_idx;
		q_re = cmd.pop_rd || (cmd.vclr_en && vclr_more);
		q_ra = cmd.vclr_en ? vclr_cnt_q[AW-1:0] : head_q[AW-1:0];
	end

	// memory arrays
	always_ff @(posedge clk) begin
		if (occ_we) occ_mem[occ_wa] <= occ_wd;
		if (cmd.occ_rd) occ_rd_q <= occ_mem[q_rd_q];
		if (vis_we) vis_mem[vis_wa] <= vis_wd;
		if (cmd.nb_rd) vis_rd_q <= vis_mem[nb_idx];
		if (q_we) q_mem[q_wa] <= q_wd;
		if (q_re) q_rd_q <= q_mem[q_ra];
	end

	// input latch and popped cell
	always_ff @(posedge clk) begin
		if (take) begin
			cmd_q     <= in_cmd;
			req_row_q <= in_row;
			req_col_q <= in_col;
			occ_val_q <= in_occ;
		end
		if (cmd.occ_rd) idx_q <= q_rd_q;
	end

	// control counters and object position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q    <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			vclr_cnt_q <= '0;
			vclr_v_s1  <= 1'b0;
			k_q        <= '0;
			obj_row_q  <= '0;
			obj_col_q  <= '0;
			found_q    <= 1'b0;
		end else begin
			if (cmd.sweep_en) sweep_q <= sweep_q + 1'b1;
			if (cmd.set_wr) found_q <= req_in_grid;
			if (cmd.start) begin
				head_q     <= '0;
				tail_q     <= (AW+1)'(1);
				vclr_cnt_q <= '0;
				vclr_v_s1  <= 1'b0;
				found_q    <= 1'b0;
			end
			if (cmd.pop_rd) head_q <= head_q + 1'b1;
			if (cmd.nb_init) k_q <= '0;
			if (cmd.nb_next) k_q <= k_q + 1'b1;
			if (cmd.nb_wr && !vis_rd_q) tail_q <= tail_q + 1'b1;
			if (cmd.upd_mark) begin
				obj_row_q <= idx_q[AW-1:CW];
				obj_col_q <= idx_q[CW-1:0];
				found_q   <= 1'b1;
			end
			if (cmd.vclr_en) begin
				vclr_v_s1 <= vclr_more;
				if (vclr_more) vclr_cnt_q <= vclr_cnt_q + 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_found <= found_q;
			out_row   <= (cmd_q == nfcp_pkg::CMD_SET) ? req_row_q : obj_row9[5:0];
			out_col   <= (cmd_q == nfcp_pkg::CMD_SET) ? req_col_q : obj_col9[5:0];
		end
	end

	// status to the controller
	always_comb begin
		stat.sweep_done   = sweep_q == {AW{1'b1}};
		stat.cmd_place    = cmd_q == nfcp_pkg::CMD_PLACE;
		stat.req_in_grid  = req_in_grid;
		stat.queue_empty  = head_q == tail_q;
		stat.occ_free     = !occ_rd_q;
		stat.nb_in_bounds = nb_in;
		stat.nb_last      = k_q == nfcp_pkg::NB_LAST;
		stat.vclr_done    = !vclr_more && !vclr_v_s1;
		stat.out_free     = !out_valid || out_ready;
	end
endmodule
`default_nettype wire

@@ rtl/core/nfcp_ctrl.sv @@
// placer controller: clearing pass, command decode and search sequencing
`default_nettype none
module nfcp_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire nfcp_pkg::dp_stat_t  stat,
	output nfcp_pkg::ctrl_cmd_t      cmd
);
	localparam logic [3:0] ST_CLRMEM = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_DEC    = 4'd2;
	localparam logic [3:0] ST_POP    = 4'd3;
	localparam logic [3:0] ST_POPW   = 4'd4;
	localparam logic [3:0] ST_OCCW   = 4'd5;
	localparam logic [3:0] ST_NBRD   = 4'd6;
	localparam logic [3:0] ST_NBWR   = 4'd7;
	localparam logic [3:0] ST_UPD1   = 4'd8;
	localparam logic [3:0] ST_UPD2   = 4'd9;
	localparam logic [3:0] ST_VCLR   = 4'd10;
	localparam logic [3:0] ST_EMIT   = 4'd11;

	logic [3:0] state_q, state_d;

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLRMEM: begin
				cmd.sweep_en = 1'b1;
				if (stat.sweep_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = ST_DEC;
			end
			ST_DEC: begin
				if (!stat.cmd_place) begin
					cmd.set_wr = 1'b1;
					state_d    = ST_EMIT;
				end else begin
					cmd.start = 1'b1;
					state_d   = stat.req_in_grid ? ST_POP : ST_EMIT;
				end
			end
			ST_POP: begin
				if (stat.queue_empty) begin
					state_d = ST_VCLR;
				end else begin
					cmd.pop_rd = 1'b1;
					state_d    = ST_POPW;
				end
			end
			ST_POPW: begin
				cmd.occ_rd = 1'b1;
				state_d    = ST_OCCW;
			end
			ST_OCCW: begin
				cmd.nb_init = 1'b1;
				state_d     = stat.occ_free ? ST_UPD1 : ST_NBRD;
			end
			ST_NBRD: begin
				if (stat.nb_in_bounds) begin
					cmd.nb_rd = 1'b1;
					state_d   = ST_NBWR;
				end else begin
					cmd.nb_next = 1'b1;
					if (stat.nb_last) state_d = ST_POP;
				end
			end
			ST_NBWR: begin
				cmd.nb_wr   = 1'b1;
				cmd.nb_next = 1'b1;
				state_d     = stat.nb_last ? ST_POP : ST_NBRD;
			end
			ST_UPD1: begin
				cmd.upd_free = 1'b1;
				state_d      = ST_UPD2;
			end
			ST_UPD2: begin
				cmd.upd_mark = 1'b1;
				state_d      = ST_VCLR;
			end
			ST_VCLR: begin
				cmd.vclr_en = 1'b1;
				if (stat.vclr_done) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLRMEM;
		end else begin
			state_q <= state_d;
		end
	end
endmodule
`default_nettype wire

@@ rtl/core/nearest_free_cell_placer_core.sv @@
// Nearest free cell placer: one placed object on an occupancy grid.
// Words arrive on cmd_ch (valid/ready). A set word writes one cell's
// occupancy bit; a place word runs a breadth-first search over the 8
// neighbors from the requested cell, moves the object to the first free
// cell and reports it. Each word gives exactly one result word on res_ch.
// grid_rows and grid_cols are written over the APB port; the user writes
// them only while idle, which the block does not enforce. After reset a
// clearing pass sweeps all 2**(clog2(MAX_ROWS)+clog2(MAX_COLS)) cells (4096
// at the defaults) of occupancy and visited memories, one cell a cycle;
// cmd_ch is not ready until it ends. One word is worked at a time. A set,
// or a place whose start is off the grid, goes from decode to the result.
// A place pops queued cells and reads their occupancy; each in-grid and
// unvisited neighbor of an occupied cell is marked and queued. At a free
// cell the old cell is freed and the new one marked; found or not, the
// visited marks of all queued cells are then cleared. The search loop makes
// one memory read a cycle. A stalled result waits in the output register;
// the next word is accepted meanwhile but its result waits until then.
`default_nettype none
module nearest_free_cell_placer_core #(
	parameter int MAX_ROWS = nfcp_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = nfcp_pkg::MAX_COLS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	nfcp_in_if.sink          cmd_ch,
	nfcp_out_if.source       res_ch,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	localparam int DW = nfcp_pkg::DIM_W;

	// size registers
	logic [6:0] grid_rows_q, grid_cols_q;
	logic       reg_idx;
	assign reg_idx = paddr[2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q <= nfcp_pkg::GRID_RESET;
			grid_cols_q <= nfcp_pkg::GRID_RESET;
		end else if (psel && penable && pwrite) begin
			if (reg_idx == nfcp_pkg::REG_GRID_ROWS) grid_rows_q <= pwdata[6:0];
			if (reg_idx == nfcp_pkg::REG_GRID_COLS) grid_cols_q <= pwdata[6:0];
		end
	end

	// register read
	always_comb begin
		if (reg_idx == nfcp_pkg::REG_GRID_ROWS) prdata = 32'(grid_rows_q);
		else prdata = 32'(grid_cols_q);
	end

	// rows and columns in use
	logic [DW-1:0] rows_used, cols_used;
	always_comb begin
		rows_used = (DW'(grid_rows_q) < DW'(MAX_ROWS)) ? DW'(grid_rows_q) : DW'(MAX_ROWS);
		cols_used = (DW'(grid_cols_q) < DW'(MAX_COLS)) ? DW'(grid_cols_q) : DW'(MAX_COLS);
	end

	nfcp_pkg::ctrl_cmd_t cmd;
	nfcp_pkg::dp_stat_t  stat;
	logic                in_ready;

	assign cmd_ch.ready = in_ready;

	nfcp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd_ch.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	nfcp_dp #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.take      (cmd_ch.valid && in_ready),
		.in_cmd    (cmd_ch.cmd),
		.in_row    (cmd_ch.req_row),
		.in_col    (cmd_ch.req_col),
		.in_occ    (cmd_ch.occ_value),
		.rows_used (rows_used),
		.cols_used (cols_used),
		.out_valid (res_ch.valid),
		.out_ready (res_ch.ready),
		.out_found (res_ch.found),
		.out_row   (res_ch.out_row),
		.out_col   (res_ch.out_col)
	);

	// one occupancy write source at a time
	a_occ_wr_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.sweep_en, cmd.set_wr, cmd.upd_free, cmd.upd_mark}))
		else $error("more than one occupancy write source");

	// a result is loaded only into a free output register
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> stat.out_free)
		else $error("result loaded over a waiting result");

	// only one word in work: no accept right after an accept
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_ch.valid && in_ready) |=> !in_ready)
		else $error("second word accepted while one is in work");
endmodule
`default_nettype wire
